>>> hdl/gemv_pkg.sv
// ============================================================================
// gemv_pkg
// Shared types and constants of the GEMV row dot product engine: register
// indexes, mode codes and the command and status bundles that pass between
// the controller and the datapath.
// ============================================================================
`default_nettype none

package gemv_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_GAIN      = 3'd0,
        REG_BETA_GAIN       = 3'd1,
        REG_BIAS_GAIN       = 3'd2,
        REG_ADDEND_GAIN     = 3'd3,
        REG_BIAS_MODE       = 3'd4,
        REG_ADDEND_ENABLE   = 3'd5,
        REG_ACTIVATION_MODE = 3'd6,
        REG_SCALAR_BIAS     = 3'd7
    } cfg_reg_t;

    // Bias mode codes.
    localparam logic [1:0] BIAS_NONE   = 2'd0;
    localparam logic [1:0] BIAS_SCALAR = 2'd1;
    localparam logic [1:0] BIAS_ROW    = 2'd2;

    // Activation mode codes.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_RELU  = 2'd1;
    localparam logic [1:0] ACT_RELU6 = 2'd2;

    // Width of the epilogue sum and the magnitude limit of one scaled term.
    localparam int SUM_W           = 64;
    localparam int TERM_LIMIT_LOG2 = 60;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_DATA   = 3'd0,
        MUL_ACC_LO = 3'd1,
        MUL_ACC_HI = 3'd2,
        MUL_BETA   = 3'd3,
        MUL_BIAS   = 3'd4,
        MUL_ADDEND = 3'd5
    } mul_sel_t;

    // Update applied to the epilogue sum register.
    typedef enum logic [2:0] {
        SUM_HOLD   = 3'd0,
        SUM_ALPHA  = 3'd1,
        SUM_BETA   = 3'd2,
        SUM_BIAS   = 3'd3,
        SUM_ADDEND = 3'd4
    } sum_op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     lo_save;
        logic     acc_update;
        sum_op_t  sum_op;
        logic     emit;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_item;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/gemv_ctrl.sv
// ============================================================================
// gemv_ctrl
// Sequencer of the GEMV engine: one multiply and one accumulate per element,
// then the epilogue steps on the shared multiplier for the row's last element.
// ============================================================================
`default_nettype none

module gemv_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gemv_pkg::dp_stat_t stat,
    output gemv_pkg::dp_cmd_t       cmd
);
    import gemv_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MUL    = 10'b00_0000_0010,
        S_ACC    = 10'b00_0000_0100,
        S_ALO    = 10'b00_0000_1000,
        S_AHI    = 10'b00_0001_0000,
        S_ACOMB  = 10'b00_0010_0000,
        S_TBETA  = 10'b00_0100_0000,
        S_TBIAS  = 10'b00_1000_0000,
        S_TADD   = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_DATA;
        cmd.sum_op  = SUM_HOLD;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_sel = MUL_DATA;
                state_next  = S_ACC;
            end
            S_ACC: begin
                cmd.acc_update = 1'b1;
                state_next     = stat.last_item ? S_ALO : S_IDLE;
            end
            S_ALO: begin
                cmd.mul_sel = MUL_ACC_LO;
                state_next  = S_AHI;
            end
            S_AHI: begin
                cmd.lo_save = 1'b1;
                cmd.mul_sel = MUL_ACC_HI;
                state_next  = S_ACOMB;
            end
            S_ACOMB: begin
                cmd.sum_op  = SUM_ALPHA;
                cmd.mul_sel = MUL_BETA;
                state_next  = S_TBETA;
            end
            S_TBETA: begin
                cmd.sum_op  = SUM_BETA;
                cmd.mul_sel = MUL_BIAS;
                state_next  = S_TBIAS;
            end
            S_TBIAS: begin
                cmd.sum_op  = SUM_BIAS;
                cmd.mul_sel = MUL_ADDEND;
                state_next  = S_TADD;
            end
            S_TADD: begin
                cmd.sum_op = SUM_ADDEND;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/gemv_dp.sv
// ============================================================================
// gemv_dp
// Datapath of the GEMV engine: configuration registers, input capture, the
// shared multiplier, the saturating accumulator, the epilogue sum and the
// result register.
// ============================================================================
`default_nettype none

module gemv_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ACC_WIDTH  = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gemv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]          cfg_wr_data,
    input  wire logic signed [DATA_WIDTH-1:0]   s_vec_elem,
    input  wire logic signed [DATA_WIDTH-1:0]   s_mat_elem,
    input  wire logic                           s_skip_product,
    input  wire logic                           s_last_of_row,
    input  wire logic signed [DATA_WIDTH-1:0]   s_old_result,
    input  wire logic signed [DATA_WIDTH-1:0]   s_bias_elem,
    input  wire logic signed [DATA_WIDTH-1:0]   s_addend_elem,
    input  wire gemv_pkg::dp_cmd_t              cmd,
    output gemv_pkg::dp_stat_t                  stat,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]        m_row_result,
    output logic                                m_saturated
);
    import gemv_pkg::*;

    // The accumulator is multiplied by alpha in two halves.
    localparam int HALF_W  = (ACC_WIDTH + 1) / 2;
    localparam int MUL_A_W = ((HALF_W > DATA_WIDTH) ? HALF_W : DATA_WIDTH) + 1;
    localparam int PROD_W  = MUL_A_W + DATA_WIDTH;
    localparam int WIDE_W  = PROD_W + HALF_W;
    localparam int EXT_W   = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

    localparam logic signed [DATA_WIDTH-1:0] ALPHA_ONE = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [ACC_WIDTH-1:0]  ACC_MAX   = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0]  ACC_MIN   = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0]     TERM_MAX  = WIDE_W'(1) << TERM_LIMIT_LOG2;
    localparam logic signed [WIDE_W-1:0]     TERM_MIN  = -TERM_MAX;
    localparam logic signed [SUM_W-1:0]      SIX_Q     = SUM_W'(6) << FRAC_BITS;
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic signed [DATA_WIDTH-1:0] alpha_gain_reg;
    logic signed [DATA_WIDTH-1:0] beta_gain_reg;
    logic signed [DATA_WIDTH-1:0] bias_gain_reg;
    logic signed [DATA_WIDTH-1:0] addend_gain_reg;
    logic [1:0]                   bias_mode_reg;
    logic                         addend_enable_reg;
    logic [1:0]                   activation_mode_reg;
    logic signed [DATA_WIDTH-1:0] scalar_bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_gain_reg      <= ALPHA_ONE;
            beta_gain_reg       <= '0;
            bias_gain_reg       <= '0;
            addend_gain_reg     <= '0;
            bias_mode_reg       <= BIAS_NONE;
            addend_enable_reg   <= 1'b0;
            activation_mode_reg <= ACT_NONE;
            scalar_bias_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ALPHA_GAIN:      alpha_gain_reg      <= cfg_wr_data;
                REG_BETA_GAIN:       beta_gain_reg       <= cfg_wr_data;
                REG_BIAS_GAIN:       bias_gain_reg       <= cfg_wr_data;
                REG_ADDEND_GAIN:     addend_gain_reg     <= cfg_wr_data;
                REG_BIAS_MODE:       bias_mode_reg       <= cfg_wr_data[1:0];
                REG_ADDEND_ENABLE:   addend_enable_reg   <= cfg_wr_data[0];
                REG_ACTIVATION_MODE: activation_mode_reg <= cfg_wr_data[1:0];
                REG_SCALAR_BIAS:     scalar_bias_reg     <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Captured input item.
    logic signed [DATA_WIDTH-1:0] vec_reg;
    logic signed [DATA_WIDTH-1:0] mat_reg;
    logic                         skip_reg;
    logic                         last_reg;
    logic signed [DATA_WIDTH-1:0] old_reg;
    logic signed [DATA_WIDTH-1:0] bias_elem_reg;
    logic signed [DATA_WIDTH-1:0] addend_elem_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            vec_reg         <= s_vec_elem;
            mat_reg         <= s_mat_elem;
            skip_reg        <= s_skip_product;
            last_reg        <= s_last_of_row;
            old_reg         <= s_old_result;
            bias_elem_reg   <= s_bias_elem;
            addend_elem_reg <= s_addend_elem;
        end
    end

    // Shared multiplier with registered product.
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     lo_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_DATA: begin
                mul_a = MUL_A_W'(vec_reg);
                mul_b = mat_reg;
            end
            MUL_ACC_LO: begin
                mul_a = $signed(MUL_A_W'(acc_reg[HALF_W-1:0]));
                mul_b = alpha_gain_reg;
            end
            MUL_ACC_HI: begin
                mul_a = MUL_A_W'($signed(acc_reg[ACC_WIDTH-1:HALF_W]));
                mul_b = alpha_gain_reg;
            end
            MUL_BETA: begin
                mul_a = MUL_A_W'(old_reg);
                mul_b = beta_gain_reg;
            end
            MUL_BIAS: begin
                mul_a = MUL_A_W'((bias_mode_reg == BIAS_SCALAR) ? scalar_bias_reg
                                                                : bias_elem_reg);
                mul_b = bias_gain_reg;
            end
            MUL_ADDEND: begin
                mul_a = MUL_A_W'(addend_elem_reg);
                mul_b = addend_gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.lo_save) begin
            lo_reg <= prod_reg;
        end
    end

    // Saturating accumulator; the product is floored by the arithmetic shift.
    logic signed [PROD_W-1:0]    prod_sh;
    logic signed [EXT_W-1:0]     acc_sum;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic                        sat_seen_reg;
    logic                        sat_seen_next;

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign acc_sum = EXT_W'(acc_reg) + EXT_W'(prod_sh);

    always_comb begin
        acc_next      = acc_reg;
        sat_seen_next = sat_seen_reg;
        if (cmd.emit) begin
            acc_next      = '0;
            sat_seen_next = 1'b0;
        end else if (cmd.acc_update && !skip_reg) begin
            if (acc_sum > EXT_W'(ACC_MAX)) begin
                acc_next      = ACC_MAX;
                sat_seen_next = 1'b1;
            end else if (acc_sum < EXT_W'(ACC_MIN)) begin
                acc_next      = ACC_MIN;
                sat_seen_next = 1'b1;
            end else begin
                acc_next = acc_sum[ACC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            sat_seen_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            sat_seen_reg <= sat_seen_next;
        end
    end

    // Epilogue sum. The alpha term joins both halves, then is clamped.
    logic signed [WIDE_W-1:0] wide_sum;
    logic signed [WIDE_W-1:0] wide_sh;
    logic signed [WIDE_W-1:0] alpha_clamped;
    logic signed [SUM_W-1:0]  alpha_term;
    logic signed [SUM_W-1:0]  small_term;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     beta_en;
    logic                     bias_en;

    assign wide_sum   = (WIDE_W'(prod_reg) <<< HALF_W) + WIDE_W'(lo_reg);
    assign wide_sh    = wide_sum >>> FRAC_BITS;
    assign alpha_clamped = (wide_sh > TERM_MAX) ? TERM_MAX
                         : (wide_sh < TERM_MIN) ? TERM_MIN : wide_sh;
    assign alpha_term = SUM_W'(alpha_clamped);
    assign small_term = SUM_W'(prod_sh);
    assign beta_en    = (beta_gain_reg != '0);
    assign bias_en    = (bias_mode_reg == BIAS_SCALAR) || (bias_mode_reg == BIAS_ROW);

    always_comb begin
        case (cmd.sum_op)
            SUM_HOLD:   sum_next = sum_reg;
            SUM_ALPHA:  sum_next = alpha_term;
            SUM_BETA:   sum_next = beta_en ? sum_reg + small_term : sum_reg;
            SUM_BIAS:   sum_next = bias_en ? sum_reg + small_term : sum_reg;
            SUM_ADDEND: sum_next = addend_enable_reg ? sum_reg + small_term : sum_reg;
            default:    sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    // Activation, then saturation to the output range.
    logic signed [SUM_W-1:0]      act_val;
    logic signed [DATA_WIDTH-1:0] result_next;
    logic                         sat_next;

    always_comb begin
        act_val = sum_reg;
        if (((activation_mode_reg == ACT_RELU) || (activation_mode_reg == ACT_RELU6))
            && (act_val < 0)) begin
            act_val = '0;
        end
        if ((activation_mode_reg == ACT_RELU6) && (act_val > SIX_Q)) begin
            act_val = SIX_Q;
        end
        sat_next = sat_seen_reg;
        if (act_val > SUM_W'(OUT_MAX)) begin
            result_next = OUT_MAX;
            sat_next    = 1'b1;
        end else if (act_val < SUM_W'(OUT_MIN)) begin
            result_next = OUT_MIN;
            sat_next    = 1'b1;
        end else begin
            result_next = act_val[DATA_WIDTH-1:0];
        end
    end

    // Result register.
    logic                         m_valid_reg;
    logic signed [DATA_WIDTH-1:0] row_result_reg;
    logic                         saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            row_result_reg <= result_next;
            saturated_reg  <= sat_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_result   = row_result_reg;
    assign m_saturated    = saturated_reg;
    assign stat.last_item = last_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

>>> hdl/gemv_row_dot_with_epilogue.sv
// An element that is not the last of its row passes through transfer, multiply and
// accumulate steps before the engine takes the next element. The last element also runs
// the epilogue steps before its result reaches the output register, which it does only
// once the previous result has been taken. The single shared multiplier serializes the
// epilogue: it runs alpha in two halves. Reset (aresetn low, synchronous) restores the
// configuration registers and controller state, and clears the accumulator and output valid.
// ============================================================================
// gemv_row_dot_with_epilogue
// Row dot product of a GEMV with bias, addend and activation epilogue in
// signed fixed point.
// ============================================================================
`default_nettype none

module gemv_row_dot_with_epilogue #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ACC_WIDTH  = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [gemv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]          cfg_wr_data,
    // Element stream.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]   s_vec_elem,
    input  wire logic signed [DATA_WIDTH-1:0]   s_mat_elem,
    input  wire logic                           s_skip_product,
    input  wire logic                           s_last_of_row,
    input  wire logic signed [DATA_WIDTH-1:0]   s_old_result,
    input  wire logic signed [DATA_WIDTH-1:0]   s_bias_elem,
    input  wire logic signed [DATA_WIDTH-1:0]   s_addend_elem,
    // Row results.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [DATA_WIDTH-1:0]        m_row_result,
    output logic                                m_saturated
);
    import gemv_pkg::*;

    // The controller walks each transferred element through a multiply and
    // an accumulate step. On the last element of a row it continues with the
    // epilogue: the accumulator times alpha is formed from its low and high
    // halves, then the beta, bias and addend terms are each multiplied in one
    // step and added in the next, overlapped on the multiplier. The finished
    // value passes activation and saturation into the result register.
    //
    // The result register decouples the two sides: elements of the next row
    // keep flowing while a result waits to be taken. Only a further row end
    // waits, in the final step, until the result register is free.

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gemv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gemv_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_vec_elem     (s_vec_elem),
        .s_mat_elem     (s_mat_elem),
        .s_skip_product (s_skip_product),
        .s_last_of_row  (s_last_of_row),
        .s_old_result   (s_old_result),
        .s_bias_elem    (s_bias_elem),
        .s_addend_elem  (s_addend_elem),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_result   (m_row_result),
        .m_saturated    (m_saturated)
    );

endmodule

`default_nettype wire

>>> hdl/gemv_checker.sv
// ============================================================================
// gemv_checker
// Port-level checks of the GEMV engine, bound to the top level.
// ============================================================================
`default_nettype none

module gemv_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [DATA_WIDTH-1:0] m_row_result,
    input wire logic                  m_saturated
);

    // Reset empties the result register.
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An element transfer keeps the engine busy in the following cycle.
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("element accepted while previous one still in work");

    // A new result is only loaded from the epilogue, when input is closed.
    a_result_from_epilogue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while engine was idle");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_result) && $stable(m_saturated))
        else $error("stalled result changed");

endmodule

bind gemv_row_dot_with_epilogue gemv_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_gemv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_row_result (m_row_result),
    .m_saturated  (m_saturated)
);

`default_nettype wire

>>> sim/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the GEMV row dot product engine. Rows of element
// pairs go in over a valid/ready stream. A cycle-free predictor rebuilds the
// saturating accumulator and the alpha/beta/bias/addend epilogue with its
// activation, and each row result that comes out is checked against it.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gemv_pkg::*;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 64;

    // Quiet cycles after the last result before the registers are touched.
    localparam int SETTLE_CYCLES = 20;
    // Cycles the receiver refuses results in the back-pressure phase.
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ELEMS   = 92;
    localparam int DRAIN_LIMIT   = 20000;

    // The package has no names for the two spare mode codes.
    localparam logic [1:0] BIAS_UNUSED = 2'd3;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic signed [31:0]  Q_ONE     = 32'sh0001_0000;
    localparam logic signed [31:0]  Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]  Q_MIN     = 32'sh8000_0000;
    localparam logic signed [63:0]  ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]  ACC_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0]  OUT_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0]  OUT_MIN   = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [63:0]  RELU6_TOP = 64'sd6 <<< FRAC_BITS;
    localparam logic signed [127:0] TERM_MAX  = 128'sd1 <<< TERM_LIMIT_LOG2;

    typedef struct {
        logic signed [31:0] vec_elem;
        logic signed [31:0] mat_elem;
        logic               skip_product;
        logic               last_of_row;
        logic signed [31:0] old_result;
        logic signed [31:0] bias_elem;
        logic signed [31:0] addend_elem;
    } row_elem_t;

    typedef struct {
        logic signed [31:0] row_result;
        logic               saturated;
    } row_out_t;

    typedef struct {
        logic signed [31:0] alpha_gain;
        logic signed [31:0] beta_gain;
        logic signed [31:0] bias_gain;
        logic signed [31:0] addend_gain;
        logic [1:0]         bias_mode;
        logic               addend_enable;
        logic [1:0]         activation_mode;
        logic signed [31:0] scalar_bias;
    } engine_cfg_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [DATA_WIDTH-1:0]        cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_vec_elem;
    logic signed [DATA_WIDTH-1:0] s_mat_elem;
    logic                         s_skip_product;
    logic                         s_last_of_row;
    logic signed [DATA_WIDTH-1:0] s_old_result;
    logic signed [DATA_WIDTH-1:0] s_bias_elem;
    logic signed [DATA_WIDTH-1:0] s_addend_elem;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [DATA_WIDTH-1:0] m_row_result;
    logic                         m_saturated;

    // Elements waiting to be offered, and row results owed by the engine.
    row_elem_t elem_backlog[$];
    row_out_t  row_results_due[$];

    // Predictor copy of the engine state and of its registers.
    logic signed [63:0] dot_sum;
    logic               dot_clipped;
    engine_cfg_t        live_cfg;

    // Set at a rising edge when the input stream completed a transfer.
    logic in_fire;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_armed;
    int hold_cnt;

    int mismatch_count;
    int elems_moved;
    int rows_checked;
    int sat_rows;
    int settings_count;

    gemv_row_dot_with_epilogue #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vec_elem     (s_vec_elem),
        .s_mat_elem     (s_mat_elem),
        .s_skip_product (s_skip_product),
        .s_last_of_row  (s_last_of_row),
        .s_old_result   (s_old_result),
        .s_bias_elem    (s_bias_elem),
        .s_addend_elem  (s_addend_elem),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_result   (m_row_result),
        .m_saturated    (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Exact floor(x * g / 2^FRAC_BITS), with its magnitude clamped to the term
    // limit. The clamp cannot move a result that still fits in Q16.16.
    function automatic logic signed [63:0] scale_q(input logic signed [63:0] x,
                                                   input logic signed [31:0] g);
        logic signed [127:0] wide;
        wide = $signed({{64{x[63]}}, x}) * $signed({{96{g[31]}}, g});
        wide = wide >>> FRAC_BITS;
        if (wide > TERM_MAX) begin
            wide = TERM_MAX;
        end else if (wide < -TERM_MAX) begin
            wide = -TERM_MAX;
        end
        return wide[63:0];
    endfunction

    // Folds one element into the running dot product. On the last element of
    // a row it also builds the epilogue and hands back the row result.
    function automatic bit dot_epilogue_step(input row_elem_t e, output row_out_t r);
        logic signed [63:0] prod;
        logic signed [63:0] total;
        logic               clipped;
        r.row_result = '0;
        r.saturated  = 1'b0;
        if (!e.skip_product) begin
            prod = ($signed({{32{e.vec_elem[31]}}, e.vec_elem}) *
                    $signed({{32{e.mat_elem[31]}}, e.mat_elem})) >>> FRAC_BITS;
            if (prod > 0 && dot_sum > ACC_MAX - prod) begin
                dot_sum     = ACC_MAX;
                dot_clipped = 1'b1;
            end else if (prod < 0 && dot_sum < ACC_MIN - prod) begin
                dot_sum     = ACC_MIN;
                dot_clipped = 1'b1;
            end else begin
                dot_sum = dot_sum + prod;
            end
        end
        if (!e.last_of_row) begin
            return 1'b0;
        end

        total = scale_q(dot_sum, live_cfg.alpha_gain);
        if (live_cfg.beta_gain != 0) begin
            total = total + scale_q(e.old_result, live_cfg.beta_gain);
        end
        case (live_cfg.bias_mode)
            BIAS_SCALAR: begin
                total = total + scale_q(live_cfg.scalar_bias, live_cfg.bias_gain);
            end
            BIAS_ROW: begin
                total = total + scale_q(e.bias_elem, live_cfg.bias_gain);
            end
            default: begin
            end
        endcase
        if (live_cfg.addend_enable) begin
            total = total + scale_q(e.addend_elem, live_cfg.addend_gain);
        end

        if ((live_cfg.activation_mode == ACT_RELU || live_cfg.activation_mode == ACT_RELU6)
                && total < 0) begin
            total = '0;
        end
        if (live_cfg.activation_mode == ACT_RELU6 && total > RELU6_TOP) begin
            total = RELU6_TOP;
        end

        clipped = dot_clipped;
        if (total > OUT_MAX) begin
            total   = OUT_MAX;
            clipped = 1'b1;
        end
        if (total < OUT_MIN) begin
            total   = OUT_MIN;
            clipped = 1'b1;
        end
        r.row_result = total[31:0];
        r.saturated  = clipped;
        dot_sum      = '0;
        dot_clipped  = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic engine_cfg_t make_cfg(input logic signed [31:0] alpha,
                                             input logic signed [31:0] beta,
                                             input logic signed [31:0] bias_g,
                                             input logic signed [31:0] addend_g,
                                             input logic [1:0]         bias_sel,
                                             input logic               addend_on,
                                             input logic [1:0]         act_sel,
                                             input logic signed [31:0] bias_val);
        engine_cfg_t c;
        c.alpha_gain      = alpha;
        c.beta_gain       = beta;
        c.bias_gain       = bias_g;
        c.addend_gain     = addend_g;
        c.bias_mode       = bias_sel;
        c.addend_enable   = addend_on;
        c.activation_mode = act_sel;
        c.scalar_bias     = bias_val;
        return c;
    endfunction

    function automatic void add_elem(input logic signed [31:0] vec,
                                     input logic signed [31:0] mat,
                                     input logic               skip,
                                     input logic               last,
                                     input logic signed [31:0] old,
                                     input logic signed [31:0] bias,
                                     input logic signed [31:0] addend);
        row_elem_t e;
        e.vec_elem     = vec;
        e.mat_elem     = mat;
        e.skip_product = skip;
        e.last_of_row  = last;
        e.old_result   = old;
        e.bias_elem    = bias;
        e.addend_elem  = addend;
        elem_backlog.push_back(e);
    endfunction

    // Q16.16 data: mostly small values so that the activation limits and the
    // exact low bits matter, plus full-range noise and the corners.
    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'sd1;
                    3:       return -32'sd1;
                    default: return '0;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $urandom_range(0, 524288) - 262144;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return Q_ONE;
            2:       return -Q_ONE;
            3:       return Q_MAX;
            4:       return Q_MIN;
            5:       return $urandom();
            default: return $urandom_range(0, 262144) - 131072;
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
    endtask

    // Writes every register. The mode registers sometimes get garbage in the
    // unused upper bits, which the engine has to ignore.
    task automatic load_settings(input engine_cfg_t c);
        logic [31:0] junk;
        junk = ($urandom_range(1) != 0) ? $urandom() : 32'd0;
        write_reg(REG_ALPHA_GAIN, c.alpha_gain);
        write_reg(REG_BETA_GAIN, c.beta_gain);
        write_reg(REG_BIAS_GAIN, c.bias_gain);
        write_reg(REG_ADDEND_GAIN, c.addend_gain);
        write_reg(REG_BIAS_MODE, {junk[31:2], c.bias_mode});
        write_reg(REG_ADDEND_ENABLE, {junk[31:1], c.addend_enable});
        write_reg(REG_ACTIVATION_MODE, {junk[31:2], c.activation_mode});
        write_reg(REG_SCALAR_BIAS, c.scalar_bias);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        live_cfg = c;
        settings_count++;
    endtask

    // Holds the sender back until every owed result is out, then lets a row
    // still being accumulated (one with no last element yet) settle.
    task automatic wait_idle();
        while (elem_backlog.size() != 0 || s_valid || row_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: a new element is put up at the falling edge only once the
    // previous one has completed its transfer, so valid never drops early.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        row_elem_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (elem_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt             = elem_backlog.pop_front();
                s_valid        <= 1'b1;
                s_vec_elem     <= nxt.vec_elem;
                s_mat_elem     <= nxt.mat_elem;
                s_skip_product <= nxt.skip_product;
                s_last_of_row  <= nxt.last_of_row;
                s_old_result   <= nxt.old_result;
                s_bias_elem    <= nxt.bias_elem;
                s_addend_elem  <= nxt.addend_elem;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or one long refusal counted here when armed.
    // The long refusal lets the engine's output register fill up so that the
    // next row end on the input side has to stall behind it.
    always @(negedge aclk) begin
        if (hold_armed && hold_cnt < LONG_HOLD) begin
            hold_cnt <= hold_cnt + 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both streams are sampled at the rising edge. An input transfer
    // feeds the predictor; an output transfer is checked against the oldest
    // owed result.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        row_elem_t seen;
        row_out_t  want;
        in_fire <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            seen.vec_elem     = s_vec_elem;
            seen.mat_elem     = s_mat_elem;
            seen.skip_product = s_skip_product;
            seen.last_of_row  = s_last_of_row;
            seen.old_result   = s_old_result;
            seen.bias_elem    = s_bias_elem;
            seen.addend_elem  = s_addend_elem;
            elems_moved++;
            if (dot_epilogue_step(seen, want)) begin
                row_results_due.push_back(want);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (row_results_due.size() == 0) begin
                $error("row result %h arrived with no row outstanding", m_row_result);
                mismatch_count++;
            end else begin
                want = row_results_due.pop_front();
                if (m_row_result !== want.row_result) begin
                    $error("row_result: expected %h (%0d), actual %h (%0d)",
                           want.row_result, want.row_result, m_row_result, m_row_result);
                    mismatch_count++;
                end
                if (m_saturated !== want.saturated) begin
                    $error("saturated: expected %b, actual %b", want.saturated, m_saturated);
                    mismatch_count++;
                end
                rows_checked++;
                if (want.saturated) begin
                    sat_rows++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        engine_cfg_t c;
        int          n;
        int          len;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_ALPHA_GAIN;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_vec_elem     = '0;
        s_mat_elem     = '0;
        s_skip_product = 1'b0;
        s_last_of_row  = 1'b0;
        s_old_result   = '0;
        s_bias_elem    = '0;
        s_addend_elem  = '0;
        m_ready        = 1'b0;
        in_fire        = 1'b0;
        hold_armed     = 1'b0;
        hold_cnt       = 0;
        send_idle_pct  = 7;
        recv_idle_pct  = 71;
        mismatch_count = 0;
        elems_moved    = 0;
        rows_checked   = 0;
        sat_rows       = 0;
        settings_count = 0;
        dot_sum        = '0;
        dot_clipped    = 1'b0;
        live_cfg       = make_cfg(Q_ONE, '0, '0, '0, BIAS_NONE, 1'b0, ACT_NONE, '0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register values straight out of reset: alpha is one and every other
        // term is off, so the nonzero side inputs must not leak into a result.
        add_elem(Q_MAX, Q_MAX, 1'b0, 1'b1, Q_MAX, Q_MAX, Q_MAX);
        add_elem(Q_MIN, Q_MIN, 1'b0, 1'b1, Q_MIN, Q_MIN, Q_MIN);
        add_elem(Q_MIN, Q_MAX, 1'b0, 1'b1, -32'sd1, 32'sd1, -32'sd1);
        // A product of plus and minus one LSB floors down to minus one LSB,
        // and minus one LSB squared floors to zero.
        add_elem(32'sd1, -32'sd1, 1'b0, 1'b1, '0, '0, '0);
        add_elem(-32'sd1, -32'sd1, 1'b0, 1'b1, '0, '0, '0);
        // An empty row: the only element is skipped but still closes the row.
        add_elem(Q_MAX, Q_MAX, 1'b1, 1'b1, Q_MAX, Q_MAX, Q_MAX);
        // 2.0 * 3.0, a skipped corner product, then -1.5 * 2.0.
        add_elem(32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b0, '0, '0, '0);
        add_elem(Q_MAX, Q_MIN, 1'b1, 1'b0, '0, '0, '0);
        add_elem(-32'sh0001_8000, 32'sh0002_0000, 1'b0, 1'b1, '0, '0, '0);

        // Scalar bias, addend on, upper ReLU6 clamp and lower clamp.
        wait_idle();
        load_settings(make_cfg(Q_ONE, 32'sh0000_8000, 32'sh0002_0000, -Q_ONE,
                               BIAS_SCALAR, 1'b1, ACT_RELU6, 32'sh0001_4000));
        add_elem(32'sh0002_0000, 32'sh0002_0000, 1'b0, 1'b1,
                 32'sh0002_0000, 32'sh0064_0000, Q_ONE);
        add_elem(-Q_ONE, Q_ONE, 1'b0, 1'b1, '0, Q_MAX, '0);
        add_elem(-32'sh0008_0000, Q_ONE, 1'b0, 1'b1, '0, '0, '0);

        // Per-row bias with ReLU; the addend gain is set but the term is off.
        wait_idle();
        load_settings(make_cfg(32'sh0000_8000, -Q_ONE, Q_ONE, Q_MAX,
                               BIAS_ROW, 1'b0, ACT_RELU, Q_MAX));
        add_elem(32'sh0003_0000, Q_ONE, 1'b0, 1'b0, '0, '0, '0);
        add_elem(Q_ONE, Q_ONE, 1'b0, 1'b1, Q_ONE, -32'sh0003_0000, Q_MAX);
        add_elem(Q_MAX, Q_ONE, 1'b0, 1'b1, -32'sh0004_0000, Q_ONE, Q_MIN);

        // The spare bias and activation codes do nothing; beta of zero drops
        // the old result entirely.
        wait_idle();
        load_settings(make_cfg(-Q_ONE, '0, Q_MAX, Q_ONE,
                               BIAS_UNUSED, 1'b1, ACT_UNUSED, Q_MAX));
        add_elem(32'sh0002_0000, Q_ONE, 1'b0, 1'b1, Q_MAX, Q_MAX, -Q_ONE);
        add_elem(Q_MIN, Q_MIN, 1'b0, 1'b1, Q_MIN, Q_MIN, Q_MIN);

        // Every gain at a corner.
        wait_idle();
        load_settings(make_cfg(Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                               BIAS_SCALAR, 1'b1, ACT_NONE, Q_MIN));
        add_elem(Q_MIN, Q_MIN, 1'b0, 1'b1, Q_MAX, '0, Q_MIN);
        add_elem(32'sd1, 32'sd1, 1'b1, 1'b1, Q_MIN, Q_MIN, Q_MAX);

        // Random rows, mostly short, under a new register setting per phase.
        // Every phase starts from a drained engine, so the sender also pauses
        // until all owed results have come back.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            hold_armed = 1'b0;
            if (p < RANDOM_PHASES / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 71;
            end else if (p < 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: c = make_cfg(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                BIAS_SCALAR, 1'b1, ACT_NONE, Q_MAX);
                1: c = make_cfg(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                BIAS_ROW, 1'b1, ACT_RELU, Q_MIN);
                2: c = make_cfg(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                BIAS_UNUSED, 1'b1, ACT_UNUSED, pick_q());
                default: c = make_cfg(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                      2'($urandom_range(3)), 1'($urandom_range(1)),
                                      2'($urandom_range(3)), pick_q());
            endcase
            load_settings(c);
            if (p == 2) begin
                @(posedge aclk);
                hold_cnt   = 0;
                hold_armed = 1'b1;
            end
            n = 0;
            while (n < PHASE_ELEMS) begin
                len = ($urandom_range(99) < 70) ? $urandom_range(1, 3) : $urandom_range(4, 16);
                for (int k = 0; k < len; k++) begin
                    add_elem(pick_q(), pick_q(), $urandom_range(7) == 0, k == len - 1,
                             pick_q(), pick_q(), pick_q());
                end
                n += len;
            end
        end

        // Let the last rows come out, with a bound in case one never does.
        for (int w = 0; w < DRAIN_LIMIT &&
             (elem_backlog.size() != 0 || s_valid || row_results_due.size() != 0); w++) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (elem_backlog.size() != 0 || row_results_due.size() != 0) begin
            $error("%0d row results still owed, %0d elements never sent",
                   row_results_due.size(), elem_backlog.size());
            mismatch_count++;
        end

        $display("Run covered %0d element transfers and %0d checked rows, %0d of them saturated,",
                 elems_moved, rows_checked, sat_rows);
        $display("over %0d register settings with corner gains, spare mode codes and back-pressure.",
                 settings_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // About 1200 elements, row ends under heavy stalls included, stay far below
    // this bound.
    initial begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/gemv_pkg.sv
hdl/gemv_ctrl.sv
hdl/gemv_dp.sv
hdl/gemv_row_dot_with_epilogue.sv
hdl/gemv_checker.sv
sim/tb_top.sv
